// ----- rtl/core/ttsw_pkg.sv -----
// ============================================================================
// ttsw_pkg - shared types, constants and functions
// Holds the double-dabble state type, the segment code table and the
// per-digit BCD correction used by the stopwatch display pipeline.
// ============================================================================
package ttsw_pkg;

    // Largest count that still shows in seconds: 9999.9999 s
    localparam logic [31:0] C_MAX_TICKS  = 32'd99_999_999;
    localparam logic [31:0] C_OVF_WORD   = 32'h4040_4040;
    localparam logic [7:0]  C_DP_BIT     = 8'h80;

    // Counts below the overflow limit fit in 27 bits and 8 BCD digits
    localparam int C_BIN_W        = 27;
    localparam int C_BCD_DIGITS   = 8;
    localparam int C_BCD_W        = 4 * C_BCD_DIGITS;

    // Shift steps per pipeline stage; the last stage takes the remainder
    localparam int C_DD_STAGES    = 4;
    localparam int C_STAGE_STEPS  = 7;
    localparam int C_LAST_STEPS   = C_BIN_W - (C_DD_STAGES - 1) * C_STAGE_STEPS;

    // Digit position that carries the decimal point (ones of seconds)
    localparam logic [1:0]  C_ONES_POS   = 2'd3;

    typedef struct packed {
        logic                 ovf;
        logic [C_BCD_W-1:0]   bcd;
        logic [C_BIN_W-1:0]   bin;
    } t_dd;

    // Add three to every digit of five or more before the next shift
    function automatic logic [C_BCD_W-1:0] dd_adjust(input logic [C_BCD_W-1:0] v);
        logic [C_BCD_W-1:0] r;
        r = v;
        for (int d = 0; d < C_BCD_DIGITS; d++) begin
            if (v[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = v[4*d +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // Segment code, bit0 = A .. bit6 = G
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] r;
        unique case (digit)
            4'd0:    r = 8'h3F;
            4'd1:    r = 8'h06;
            4'd2:    r = 8'h5B;
            4'd3:    r = 8'h4F;
            4'd4:    r = 8'h66;
            4'd5:    r = 8'h6D;
            4'd6:    r = 8'h7D;
            4'd7:    r = 8'h07;
            4'd8:    r = 8'h7F;
            4'd9:    r = 8'h67;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/ttsw_dabble_stage.sv -----
// ============================================================================
// ttsw_dabble_stage - one stage of the pipelined binary-to-BCD converter
// Runs P_STEPS correct-and-shift steps on the item and registers the result.
// ============================================================================
module ttsw_dabble_stage #(
    parameter int P_STEPS = ttsw_pkg::C_STAGE_STEPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ttsw_pkg::t_dd  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ttsw_pkg::t_dd  o_data
);

    logic          r_valid;
    ttsw_pkg::t_dd r_data;
    ttsw_pkg::t_dd n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < P_STEPS; s++) begin
            n_data.bcd = ttsw_pkg::dd_adjust(n_data.bcd);
            {n_data.bcd, n_data.bin} = {n_data.bcd[ttsw_pkg::C_BCD_W-2:0], n_data.bin, 1'b0};
        end
    end

    // Advance when empty or when the next stage takes the held item
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/ttsw_seg_stage.sv -----
// ============================================================================
// ttsw_seg_stage - digit window select and segment encode
// Picks four digits from the first nonzero one, at the latest the ones of
// seconds, encodes them or the overflow word, registers the display word.
// ============================================================================
module ttsw_seg_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ttsw_pkg::t_dd  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word
);

    logic        r_valid;
    logic [31:0] r_word;
    logic [31:0] n_word;
    logic [27:0] digs;      // thousands of seconds down to milliseconds
    logic [1:0]  start;
    logic [15:0] win;
    logic [3:0]  dp_mask;

    // Drop the 0.1 ms digit
    assign digs = i_data.bcd[ttsw_pkg::C_BCD_W-1:4];

    always_comb begin
        if (digs[27:24] != 4'd0) begin
            start = 2'd0;
        end else if (digs[23:20] != 4'd0) begin
            start = 2'd1;
        end else if (digs[19:16] != 4'd0) begin
            start = 2'd2;
        end else begin
            start = ttsw_pkg::C_ONES_POS;
        end
    end

    // win holds the first shown digit in its top nibble
    always_comb begin
        case (start)
            2'd0:    begin win = digs[27:12]; dp_mask = 4'b1000; end
            2'd1:    begin win = digs[23:8];  dp_mask = 4'b0100; end
            2'd2:    begin win = digs[19:4];  dp_mask = 4'b0010; end
            default: begin win = digs[15:0];  dp_mask = 4'b0001; end
        endcase
    end

    always_comb begin
        n_word = '0;
        for (int j = 0; j < 4; j++) begin
            n_word[8*j +: 8] = ttsw_pkg::seg_code(win[4*(3-j) +: 4])
                             | (dp_mask[j] ? ttsw_pkg::C_DP_BIT : 8'h00);
        end
        if (i_data.ovf) begin
            n_word = ttsw_pkg::C_OVF_WORD;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/core/timer_to_seven_segment_window.sv -----
// ============================================================================
// timer_to_seven_segment_window - stopwatch count to four-digit display word
// Stages: six register stages (capture, 4 BCD, encode).
// Throughput: one item per cycle while the sink takes results; the 27-step
//   BCD conversion is spread over four register stages of at most 7
//   correct-and-shift steps each.
// Reset: clears the stage valid bits only; data registers are not reset.
// ============================================================================
module timer_to_seven_segment_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_timer_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_segment_word
);

    localparam int N_ST = ttsw_pkg::C_DD_STAGES;

    // Capture stage: flag counts of 10000 s or more, keep the low 27 bits
    logic          r_in_valid;
    ttsw_pkg::t_dd r_in_data;
    ttsw_pkg::t_dd n_in_data;

    // Handshake chain; index k feeds stage k
    logic          st_valid [N_ST+1];
    logic          st_ready [N_ST+1];
    ttsw_pkg::t_dd st_data  [N_ST+1];

    always_comb begin
        n_in_data.ovf = i_timer_ticks > ttsw_pkg::C_MAX_TICKS;
        n_in_data.bcd = '0;
        n_in_data.bin = i_timer_ticks[ttsw_pkg::C_BIN_W-1:0];
    end

    // Take a new item whenever the capture register is empty or drains
    assign o_ready = !r_in_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= n_in_data;
        end
    end

    assign st_valid[0] = r_in_valid;
    assign st_data[0]  = r_in_data;

    // Binary-to-BCD pipeline: each stage shifts in a slice of the count
    for (genvar k = 0; k < N_ST; k++) begin : g_dd
        localparam int STEPS = (k == N_ST - 1) ? ttsw_pkg::C_LAST_STEPS
                                               : ttsw_pkg::C_STAGE_STEPS;
        ttsw_dabble_stage #(
            .P_STEPS (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k]),
            .o_ready (st_ready[k]),
            .i_data  (st_data[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (st_ready[k+1]),
            .o_data  (st_data[k+1])
        );
    end

    // Window select, segment encode and output register
    ttsw_seg_stage u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[N_ST]),
        .o_ready (st_ready[N_ST]),
        .i_data  (st_data[N_ST]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_segment_word)
    );

    // Input backpressure only when the result register is held by the sink
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while output is free");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Exactly one decimal point unless the overflow pattern is shown
    a_one_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_segment_word == ttsw_pkg::C_OVF_WORD) ||
                     ($countones({o_segment_word[31], o_segment_word[23],
                                  o_segment_word[15], o_segment_word[7]}) == 1)))
        else $error("decimal point count wrong");

    // Every shown byte lights at least one segment
    a_bytes_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_segment_word[6:0] != 7'd0) && (o_segment_word[14:8] != 7'd0) &&
                     (o_segment_word[22:16] != 7'd0) && (o_segment_word[30:24] != 7'd0)))
        else $error("blank digit in display word");

endmodule
